### rtl/ldsch_pkg.sv
// ldsch_pkg: shared types and constants of the look disk scheduler
// holds parameter defaults, request codes, the fsm state type and control structs
// no dependencies
package ldsch_pkg;

	// parameter defaults
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int CYL_BITS_DEF    = 16;

	// request function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PLAN,
		ST_SERVE,
		ST_EMPTY
	} state_t;

	// control broadcast to every cell of the sorted chain
	typedef struct packed {
		logic insert;
		logic capture;
		logic toward_high;
	} cell_ctrl_t;

	// control toward the seek accumulator and result register
	typedef struct packed {
		logic start;
		logic emit;
		logic empty;
		logic last;
		logic ovf;
	} seek_ctrl_t;

endpackage

### rtl/look_disk_scheduler.sv
// look disk scheduler: a load request is taken while idle; a start request is accepted,
// passes a planning state, then gives one result per cycle while out_ready does not stall
// it, n results for n stored requests, by a walk over the cell chain that reads one cell
// per result. an empty store gives its single result, marked not valid, after the start.
// asynchronous active-low reset clears count, overflow, head and total; the cell
// contents need no clearing, only slots below the count are ever read.
module look_disk_scheduler #(
	parameter int QUEUE_DEPTH   = ldsch_pkg::QUEUE_DEPTH_DEF,
	parameter int CYLINDER_BITS = ldsch_pkg::CYL_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [CYLINDER_BITS-1:0] cylinder,
	input  logic                     toward_high,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     served_valid,
	output logic [CYLINDER_BITS-1:0] served_cylinder,
	output logic [CYLINDER_BITS-1:0] seek_distance,
	output logic [CYLINDER_BITS:0]   seek_total,
	output logic                     last_of_run,
	output logic                     overflowed
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

	ldsch_pkg::state_t     state_q, state_d;
	ldsch_pkg::cell_ctrl_t cell_ctrl;
	ldsch_pkg::seek_ctrl_t seek_ctrl;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             run_up_q;
	logic [CNT_W-1:0] b_q;
	logic [IDX_W-1:0] ptr_q;
	logic             dir_up_q;
	logic             second_q;

	logic [CYLINDER_BITS-1:0] val [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   gt;
	logic [QUEUE_DEPTH-1:0]   below;
	logic [QUEUE_DEPTH-1:0]   occ;
	logic [QUEUE_DEPTH-1:0]   tail;
	logic [QUEUE_DEPTH:0]     below_ext;

	logic             accept, is_load, is_start, full;
	logic             slot_free, serve_fire, empty_fire, run_done;
	logic [CNT_W-1:0] below_cnt, below_dec, b_dec, cnt_dec;
	logic             plan_first_empty, plan_dir_up;
	logic             at_end, other_side, last;

	assign accept   = in_valid && in_ready;
	assign is_load  = accept && (func == ldsch_pkg::FUNC_LOAD);
	assign is_start = accept && (func == ldsch_pkg::FUNC_START);
	assign full     = (count_q == FULL);

	// occupancy and tail slot of each cell
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			occ[i]  = CNT_W'(i) < count_q;
			tail[i] = CNT_W'(i) == count_q;
		end
	end

	// sorted chain of cells
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic                     prev_gt;
		logic [CYLINDER_BITS-1:0] prev_val;
		if (g == 0) begin : g_first
			assign prev_gt  = 1'b0;
			assign prev_val = '0;
		end else begin : g_next
			assign prev_gt  = gt[g-1];
			assign prev_val = val[g-1];
		end
		ldsch_cell #(
			.CYL_W(CYLINDER_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.cyl      (cylinder),
			.occupied (occ[g]),
			.tail     (tail[g]),
			.prev_gt  (prev_gt),
			.prev_val (prev_val),
			.gt       (gt[g]),
			.val      (val[g]),
			.below    (below[g])
		);
	end

	// size of the low side: the flags form a thermometer, so encode its edge
	assign below_ext = {1'b0, below};
	always_comb begin
		below_cnt = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (below_ext[i] && !below_ext[i+1]) begin
				below_cnt = below_cnt | CNT_W'(i + 1);
			end
		end
	end

	// plan of the first sweep
	assign below_dec        = below_cnt - CNT_W'(1);
	assign plan_first_empty = run_up_q ? (below_cnt == count_q) : (below_cnt == '0);
	assign plan_dir_up      = run_up_q ^ plan_first_empty;

	// sweep walk
	assign b_dec      = b_q - CNT_W'(1);
	assign cnt_dec    = count_q - CNT_W'(1);
	assign at_end     = dir_up_q ? (CNT_W'(ptr_q) == cnt_dec) : (ptr_q == '0);
	assign other_side = !second_q && (dir_up_q ? (b_q != '0) : (b_q != count_q));
	assign last       = at_end && !other_side;

	assign serve_fire = (state_q == ldsch_pkg::ST_SERVE) && slot_free;
	assign empty_fire = (state_q == ldsch_pkg::ST_EMPTY) && slot_free;
	assign run_done   = (serve_fire && last) || empty_fire;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ldsch_pkg::ST_IDLE: begin
				if (is_start) begin
					state_d = (count_q == '0) ? ldsch_pkg::ST_EMPTY : ldsch_pkg::ST_PLAN;
				end
			end
			ldsch_pkg::ST_PLAN: begin
				state_d = ldsch_pkg::ST_SERVE;
			end
			ldsch_pkg::ST_SERVE: begin
				if (serve_fire && last) begin
					state_d = ldsch_pkg::ST_IDLE;
				end
			end
			ldsch_pkg::ST_EMPTY: begin
				if (empty_fire) begin
					state_d = ldsch_pkg::ST_IDLE;
				end
			end
			default: state_d = ldsch_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_ready              = (state_q == ldsch_pkg::ST_IDLE);
		cell_ctrl.insert      = is_load && !full;
		cell_ctrl.capture     = is_start;
		cell_ctrl.toward_high = toward_high;
		seek_ctrl.start       = is_start;
		seek_ctrl.emit        = serve_fire || empty_fire;
		seek_ctrl.empty       = (state_q == ldsch_pkg::ST_EMPTY);
		seek_ctrl.last        = (state_q == ldsch_pkg::ST_EMPTY) || last;
		seek_ctrl.ovf         = ovf_q;
	end

	// state, count and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldsch_pkg::ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cell_ctrl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (run_done) begin
				count_q <= '0;
			end
			if (is_load && full) begin
				ovf_q <= 1'b1;
			end else if (run_done) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// sweep pointer and direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_up_q <= 1'b0;
			b_q      <= '0;
			ptr_q    <= '0;
			dir_up_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (is_start) begin
				run_up_q <= toward_high;
			end
			if (state_q == ldsch_pkg::ST_PLAN) begin
				b_q      <= below_cnt;
				dir_up_q <= plan_dir_up;
				second_q <= plan_first_empty;
				ptr_q    <= plan_dir_up ? below_cnt[IDX_W-1:0] : below_dec[IDX_W-1:0];
			end else if (serve_fire) begin
				if (at_end) begin
					dir_up_q <= !dir_up_q;
					second_q <= 1'b1;
					ptr_q    <= !dir_up_q ? b_q[IDX_W-1:0] : b_dec[IDX_W-1:0];
				end else if (dir_up_q) begin
					ptr_q <= ptr_q + IDX_W'(1);
				end else begin
					ptr_q <= ptr_q - IDX_W'(1);
				end
			end
		end
	end

	// seek accumulation and result register
	ldsch_seek #(
		.CYL_W(CYLINDER_BITS)
	) u_seek (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (seek_ctrl),
		.start_cyl       (cylinder),
		.value           (val[ptr_q]),
		.slot_free       (slot_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.served_valid    (served_valid),
		.served_cylinder (served_cylinder),
		.seek_distance   (seek_distance),
		.seek_total      (seek_total),
		.last_of_run     (last_of_run),
		.overflowed      (overflowed)
	);

endmodule

### rtl/ldsch_cell.sv
// ldsch_cell: one cell of the sorted request chain
// holds one cylinder, shifts toward higher slots on insert, flags the low side of the head
// depends on ldsch_pkg
module ldsch_cell #(
	parameter int CYL_W = ldsch_pkg::CYL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ldsch_pkg::cell_ctrl_t  ctrl,
	input  logic [CYL_W-1:0]       cyl,
	input  logic                   occupied,
	input  logic                   tail,
	input  logic                   prev_gt,
	input  logic [CYL_W-1:0]       prev_val,
	output logic                   gt,
	output logic [CYL_W-1:0]       val,
	output logic                   below
);

	logic [CYL_W-1:0] val_q;
	logic             below_q;

	// strict compare keeps equal cylinders behind the ones already held
	assign gt    = occupied && (val_q > cyl);
	assign val   = val_q;
	assign below = below_q;

	// insertion: take the neighbor's value when it moves up, else the new request
	always_ff @(posedge clk) begin
		if (ctrl.insert && (prev_gt || gt || tail)) begin
			val_q <= prev_gt ? prev_val : cyl;
		end
	end

	// low side of the head for the run: strict on an upward run, inclusive downward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_q <= 1'b0;
		end else if (ctrl.capture) begin
			below_q <= occupied && (ctrl.toward_high ? (val_q < cyl) : (val_q <= cyl));
		end
	end

endmodule

### rtl/ldsch_seek.sv
// ldsch_seek: head tracking, seek accumulation and the result register
// computes distance and running total for each served request
// depends on ldsch_pkg
module ldsch_seek #(
	parameter int CYL_W = ldsch_pkg::CYL_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ldsch_pkg::seek_ctrl_t  ctrl,
	input  logic [CYL_W-1:0]       start_cyl,
	input  logic [CYL_W-1:0]       value,
	output logic                   slot_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   served_valid,
	output logic [CYL_W-1:0]       served_cylinder,
	output logic [CYL_W-1:0]       seek_distance,
	output logic [CYL_W:0]         seek_total,
	output logic                   last_of_run,
	output logic                   overflowed
);

	logic             out_valid_q;
	logic [CYL_W-1:0] head_q;
	logic [CYL_W:0]   total_q;
	logic             served_valid_q;
	logic [CYL_W-1:0] served_cylinder_q;
	logic [CYL_W-1:0] seek_distance_q;
	logic [CYL_W:0]   seek_total_q;
	logic             last_q;
	logic             ovf_q;

	logic [CYL_W-1:0] delta;
	logic [CYL_W:0]   sum;

	// absolute head movement and new running total
	assign delta = (value >= head_q) ? (value - head_q) : (head_q - value);
	assign sum   = total_q + {1'b0, delta};

	assign slot_free = !out_valid_q || out_ready;

	// head and total state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			head_q      <= '0;
			total_q     <= '0;
		end else begin
			if (ctrl.start) begin
				head_q  <= start_cyl;
				total_q <= '0;
			end else if (ctrl.emit && !ctrl.empty) begin
				head_q  <= value;
				total_q <= sum;
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			served_valid_q    <= !ctrl.empty;
			served_cylinder_q <= ctrl.empty ? '0 : value;
			seek_distance_q   <= ctrl.empty ? '0 : delta;
			seek_total_q      <= ctrl.empty ? '0 : sum;
			last_q            <= ctrl.last;
			ovf_q             <= ctrl.ovf;
		end
	end

	assign out_valid       = out_valid_q;
	assign served_valid    = served_valid_q;
	assign served_cylinder = served_cylinder_q;
	assign seek_distance   = seek_distance_q;
	assign seek_total      = seek_total_q;
	assign last_of_run     = last_q;
	assign overflowed      = ovf_q;

endmodule

### sim/look_disk_scheduler_test.sv
// look_disk_scheduler_test: self-checking bench for the look disk scheduler
// drives load and start requests, predicts every served request and compares results
// depends on rtl/ldsch_pkg.sv and rtl/look_disk_scheduler.sv
module look_disk_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = ldsch_pkg::QUEUE_DEPTH_DEF;
	localparam int CW    = ldsch_pkg::CYL_BITS_DEF;

	// one served request as it leaves the block
	typedef struct packed {
		logic          hit;
		logic [CW-1:0] cyl;
		logic [CW-1:0] span;
		logic [CW:0]   total;
		logic          last;
		logic          ovf;
	} service_t;

	// one row of the directed stimulus
	typedef struct packed {
		logic          op;
		logic [CW-1:0] cyl;
		logic          up;
		logic          typed;
		service_t      want;
	} row_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic          func;
	logic [CW-1:0] cylinder;
	logic          toward_high;
	logic          out_valid;
	logic          out_ready;
	logic          served_valid;
	logic [CW-1:0] served_cylinder;
	logic [CW-1:0] seek_distance;
	logic [CW:0]   seek_total;
	logic          last_of_run;
	logic          overflowed;

	// predictor state
	logic [CW-1:0] pending_cyl[$];
	logic          spill_seen = 1'b0;
	logic [CW-1:0] head_cyl = '0;
	logic [CW+1:0] seek_run = '0;
	service_t      run_services[$];
	service_t      due_services[$];

	int faults    = 0;
	int taken     = 0;
	int offered   = 0;
	int send_calm = 0;

	look_disk_scheduler #(
		.QUEUE_DEPTH  (DEPTH),
		.CYLINDER_BITS(CW)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.cylinder       (cylinder),
		.toward_high    (toward_high),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.served_valid   (served_valid),
		.served_cylinder(served_cylinder),
		.seek_distance  (seek_distance),
		.seek_total     (seek_total),
		.last_of_run    (last_of_run),
		.overflowed     (overflowed)
	);

	always #5 clk = ~clk;

	// hard stop in case the handshake hangs
	initial begin
		#5ms;
		$display("look_disk_scheduler regression: fail");
		$finish;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		faults++;
	endtask

	// pause before the next request; zero-pause stretches come in bursts
	function automatic int draw_pause(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// look scheduling: sorted insert on load, two sweeps on start
	function automatic void look_schedule(input logic op, input logic [CW-1:0] c, input logic up);
		service_t      s;
		logic [CW-1:0] sweep[$];
		int            pos;
		run_services.delete();
		if (op == ldsch_pkg::FUNC_LOAD) begin
			if (pending_cyl.size() >= DEPTH) begin
				spill_seen = 1'b1;
			end else begin
				// equal cylinders go behind the ones already stored
				pos = pending_cyl.size();
				while (pos > 0 && pending_cyl[pos-1] > c)
					pos--;
				pending_cyl.insert(pos, c);
			end
			return;
		end
		head_cyl = c;
		seek_run = '0;
		// empty store: one result marked not valid
		if (pending_cyl.size() == 0) begin
			s = '{1'b0, {CW{1'b0}}, {CW{1'b0}}, {(CW+1){1'b0}}, 1'b1, spill_seen};
			run_services.push_back(s);
			spill_seen = 1'b0;
			return;
		end
		// first sweep includes a request equal to the head
		if (up) begin
			foreach (pending_cyl[i])
				if (pending_cyl[i] >= c) sweep.push_back(pending_cyl[i]);
			for (int i = pending_cyl.size() - 1; i >= 0; i--)
				if (pending_cyl[i] < c) sweep.push_back(pending_cyl[i]);
		end else begin
			for (int i = pending_cyl.size() - 1; i >= 0; i--)
				if (pending_cyl[i] <= c) sweep.push_back(pending_cyl[i]);
			foreach (pending_cyl[i])
				if (pending_cyl[i] > c) sweep.push_back(pending_cyl[i]);
		end
		foreach (sweep[i]) begin
			s.hit   = 1'b1;
			s.cyl   = sweep[i];
			s.span  = (sweep[i] >= head_cyl) ? sweep[i] - head_cyl : head_cyl - sweep[i];
			seek_run = seek_run + {2'b00, s.span};
			head_cyl = sweep[i];
			s.total = seek_run[CW:0];
			s.last  = (i == sweep.size() - 1);
			s.ovf   = spill_seen;
			run_services.push_back(s);
		end
		pending_cyl.delete();
		spill_seen = 1'b0;
	endfunction

	// offer one request, then log what it should produce once accepted
	task automatic offer_request(input logic op, input logic [CW-1:0] c, input logic up,
			input logic typed, input service_t want);
		int pause;
		pause = draw_pause(send_calm);
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= op;
		cylinder    <= c;
		toward_high <= up;
		do @(posedge clk); while (!in_ready);
		offered++;
		look_schedule(op, c, up);
		if (typed) begin
			due_services.push_back(want);
		end else begin
			foreach (run_services[i])
				due_services.push_back(run_services[i]);
		end
	endtask

	// a batch of loads, random or with related cylinders, closed by a start
	task automatic offer_batch(input int loads);
		logic [CW-1:0] picks[$];
		logic [CW-1:0] base;
		logic [CW-1:0] c;
		logic [CW-1:0] head;
		int            mode;
		mode = $urandom_range(0, 3);
		base = CW'($urandom);
		repeat (loads) begin
			case (mode)
				0: c = CW'($urandom);
				// dense cluster for ties
				1: c = base + CW'($urandom_range(0, 3));
				2: c = $urandom_range(0, 1) ? {CW{1'b1}} : {CW{1'b0}};
				default: c = base ^ (CW'(1) << $urandom_range(0, CW - 1));
			endcase
			picks.push_back(c);
			offer_request(ldsch_pkg::FUNC_LOAD, c, 1'($urandom_range(0, 1)), 1'b0, '0);
		end
		// head on a stored cylinder, at an extreme, or anywhere
		case ($urandom_range(0, 3))
			0: head = (picks.size() > 0) ? picks[$urandom_range(0, picks.size() - 1)] : '0;
			1: head = $urandom_range(0, 1) ? {CW{1'b1}} : {CW{1'b0}};
			default: head = CW'($urandom);
		endcase
		offer_request(ldsch_pkg::FUNC_START, head, 1'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	// compare one result with the oldest expectation
	task automatic check_service();
		service_t want;
		taken++;
		if (due_services.size() == 0) begin
			flag_mismatch("unexpected result, cylinder", served_cylinder, 0);
			return;
		end
		want = due_services.pop_front();
		if (served_valid !== want.hit)
			flag_mismatch("served_valid", served_valid, want.hit);
		if (served_cylinder !== want.cyl)
			flag_mismatch("served_cylinder", served_cylinder, want.cyl);
		if (seek_distance !== want.span)
			flag_mismatch("seek_distance", seek_distance, want.span);
		if (seek_total !== want.total)
			flag_mismatch("seek_total", seek_total, want.total);
		if (last_of_run !== want.last)
			flag_mismatch("last_of_run", last_of_run, want.last);
		if (overflowed !== want.ovf)
			flag_mismatch("overflowed", overflowed, want.ovf);
	endtask

	// result side: random stalls plus one long hold-off to back up the input
	initial begin : drain
		int pause;
		int calm;
		out_ready = 1'b0;
		calm = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			pause = draw_pause(calm);
			if (taken == 60)
				pause = 400;
			if (pause > 0) begin
				out_ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_service();
		end
	end

	// request side: reset, directed rows, random batches, then drain
	initial begin : feed
		row_t plan [20];
		int   kind;
		int   guard;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = ldsch_pkg::FUNC_LOAD;
		cylinder    = '0;
		toward_high = 1'b0;
		plan = '{
			// empty store right after reset
			'{ldsch_pkg::FUNC_START, 16'd0, 1'b1, 1'b1,
				'{1'b0, 16'd0, 16'd0, 17'd0, 1'b1, 1'b0}},
			// single request at the top, head at the bottom
			'{ldsch_pkg::FUNC_LOAD, 16'hFFFF, 1'b0, 1'b0, '0},
			'{ldsch_pkg::FUNC_START, 16'd0, 1'b1, 1'b1,
				'{1'b1, 16'hFFFF, 16'hFFFF, 17'h0FFFF, 1'b1, 1'b0}},
			// single request at the bottom, head at the top
			'{ldsch_pkg::FUNC_LOAD, 16'd0, 1'b1, 1'b0, '0},
			'{ldsch_pkg::FUNC_START, 16'hFFFF, 1'b0, 1'b1,
				'{1'b1, 16'd0, 16'hFFFF, 17'h0FFFF, 1'b1, 1'b0}},
			// upward run with a duplicate and a request on the head
			'{ldsch_pkg::FUNC_LOAD, 16'd100, 1'b0, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'd50, 1'b1, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'd200, 1'b0, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'd50, 1'b1, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'd150, 1'b0, 1'b0, '0},
			'{ldsch_pkg::FUNC_START, 16'd150, 1'b1, 1'b0, '0},
			// downward run with pairs on both sides
			'{ldsch_pkg::FUNC_LOAD, 16'd10, 1'b1, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'd300, 1'b0, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'd10, 1'b1, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'd300, 1'b1, 1'b0, '0},
			'{ldsch_pkg::FUNC_START, 16'd10, 1'b0, 1'b0, '0},
			// empty store with the head moved
			'{ldsch_pkg::FUNC_START, 16'd1234, 1'b0, 1'b0, '0},
			// largest possible total seek
			'{ldsch_pkg::FUNC_LOAD, 16'd0, 1'b0, 1'b0, '0},
			'{ldsch_pkg::FUNC_LOAD, 16'hFFFF, 1'b1, 1'b0, '0},
			'{ldsch_pkg::FUNC_START, 16'd1, 1'b1, 1'b0, '0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r])
			offer_request(plan[r].op, plan[r].cyl, plan[r].up, plan[r].typed, plan[r].want);

		// spill over a full store first, then mostly short batches with some noise
		offer_batch(DEPTH + $urandom_range(1, 8));
		while (offered < 200) begin
			kind = $urandom_range(0, 19);
			if (kind < 3)
				offer_request($urandom_range(0, 1) ? ldsch_pkg::FUNC_START
					: ldsch_pkg::FUNC_LOAD, CW'($urandom),
					1'($urandom_range(0, 1)), 1'b0, '0);
			else if (kind == 3)
				offer_batch(DEPTH + $urandom_range(0, 4));
			else
				offer_batch($urandom_range(1, 8));
		end
		in_valid <= 1'b0;

		// wait for the last results, then a little longer for strays
		guard = 0;
		while (due_services.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		foreach (due_services[i])
			flag_mismatch("missing result, cylinder", 0, due_services[i].cyl);

		if (faults == 0)
			$display("look_disk_scheduler regression: pass");
		else
			$display("look_disk_scheduler regression: fail");
		$finish;
	end

endmodule
